>>> rtl/core/jtl_pkg.sv
package jtl_pkg;

  localparam int OFFSET_BITS = 16;

  typedef logic [OFFSET_BITS-1:0] pos_t;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_NUMBER,
    MODE_TRUE,
    MODE_FALSE,
    MODE_NULL,
    MODE_STRING
  } mode_t;

  localparam logic [3:0] KIND_LBRACE   = 4'd0;
  localparam logic [3:0] KIND_RBRACE   = 4'd1;
  localparam logic [3:0] KIND_LBRACKET = 4'd2;
  localparam logic [3:0] KIND_RBRACKET = 4'd3;
  localparam logic [3:0] KIND_COLON    = 4'd4;
  localparam logic [3:0] KIND_COMMA    = 4'd5;
  localparam logic [3:0] KIND_NUMBER   = 4'd6;
  localparam logic [3:0] KIND_TRUE     = 4'd7;
  localparam logic [3:0] KIND_FALSE    = 4'd8;
  localparam logic [3:0] KIND_NULL     = 4'd9;
  localparam logic [3:0] KIND_STRING   = 4'd10;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_UPPER_E = 8'h45;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRACKET = 8'h5D;
  localparam logic [7:0] CH_A      = 8'h61;
  localparam logic [7:0] CH_E      = 8'h65;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_L      = 8'h6C;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_S      = 8'h73;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] offset;
    logic [15:0] length;
    logic        err;
    logic        last;
    logic        done;
  } tok_t;

  typedef struct packed {
    tok_t       tok0;
    tok_t       tok1;
    logic [1:0] cnt;
  } scan_out_t;

  function automatic logic [15:0] clamp_out(input pos_t v);
    logic [32:0] w;
    w = 33'(v);
    return (w > 33'h0FFFF) ? 16'hFFFF : w[15:0];
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic continues_run(input mode_t m, input logic [7:0] c);
    logic r;
    r = 1'b0;
    case (m)
      MODE_NUMBER: r = (c == CH_MINUS) || (c == CH_PLUS) || (c == CH_DOT) ||
                       (c == CH_UPPER_E) || (c == CH_E) || is_digit(c);
      MODE_TRUE:   r = (c == CH_R) || (c == CH_U) || (c == CH_E);
      MODE_FALSE:  r = (c == CH_A) || (c == CH_L) || (c == CH_S) || (c == CH_E);
      MODE_NULL:   r = (c == CH_U) || (c == CH_L);
      default:     r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic tok_t make_tok(input logic [3:0] kind, input pos_t off,
                                    input pos_t len, input logic err,
                                    input logic done);
    tok_t t;
    t.kind   = kind;
    t.offset = clamp_out(off);
    t.length = clamp_out(len);
    t.err    = err;
    t.last   = 1'b0;
    t.done   = done;
    return t;
  endfunction

endpackage

>>> rtl/core/jtl_scan.sv
module jtl_scan
  import jtl_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       advance,
  input  logic [7:0] text_byte,
  input  logic       end_of_text,
  output scan_out_t  result
);

  mode_t mode_r, mode_nxt;
  pos_t  begin_r, begin_nxt;
  pos_t  pos_r, pos_nxt;
  logic  bs_r, bs_nxt;
  logic  halt_r, halt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      begin_r <= '0;
      pos_r   <= '0;
      bs_r    <= 1'b0;
      halt_r  <= 1'b0;
    end else if (advance) begin
      mode_r  <= mode_nxt;
      begin_r <= begin_nxt;
      pos_r   <= pos_nxt;
      bs_r    <= bs_nxt;
      halt_r  <= halt_nxt;
    end
  end

  function automatic tok_t run_tok(input mode_t m, input pos_t b, input pos_t e,
                                   input logic done);
    tok_t t;
    case (m)
      MODE_TRUE:  t = make_tok(KIND_TRUE, b, pos_t'(4), 1'b0, done);
      MODE_FALSE: t = make_tok(KIND_FALSE, b, pos_t'(5), 1'b0, done);
      MODE_NULL:  t = make_tok(KIND_NULL, b, pos_t'(4), 1'b0, done);
      default:    t = make_tok(KIND_NUMBER, b, (e > b) ? e - b : '0, 1'b0, done);
    endcase
    return t;
  endfunction

  always_comb begin
    logic       used;
    logic [1:0] n;
    pos_t       nxt;
    tok_t       res [2];
    tok_t       t;
    logic       emit;

    used = 1'b0;
    n    = 2'd0;
    emit = 1'b0;
    t    = '0;
    res[0] = '0;
    res[1] = '0;
    nxt  = (pos_r == '1) ? pos_r : pos_r + pos_t'(1);

    mode_nxt  = mode_r;
    begin_nxt = begin_r;
    pos_nxt   = pos_r;
    bs_nxt    = bs_r;
    halt_nxt  = halt_r;

    if (halt_r) begin
      if (end_of_text) begin
        halt_nxt = 1'b0;
        mode_nxt = MODE_IDLE;
        begin_nxt = '0;
        pos_nxt = '0;
        bs_nxt = 1'b0;
      end
    end else begin
      if (mode_r == MODE_STRING) begin
        used = 1'b1;
        if (bs_r) begin
          bs_nxt = 1'b0;
        end else if (text_byte == CH_BSLASH) begin
          bs_nxt = 1'b1;
        end else if (text_byte == CH_QUOTE) begin
          res[0] = make_tok(KIND_STRING, begin_r, nxt - begin_r, 1'b0, end_of_text);
          n = 2'd1;
          mode_nxt = MODE_IDLE;
        end
      end else if (mode_r != MODE_IDLE) begin
        if (continues_run(mode_r, text_byte)) begin
          used = 1'b1;
        end else begin
          res[0] = run_tok(mode_r, begin_r, pos_r, end_of_text);
          n = 2'd1;
          mode_nxt = MODE_IDLE;
        end
      end

      if (!used) begin
        case (text_byte)
          CH_SPACE, CH_TAB, CH_FF, CH_CR, CH_LF: emit = 1'b0;
          CH_LBRACE: begin
            emit = 1'b1;
            t = make_tok(KIND_LBRACE, pos_r, pos_t'(1), 1'b0, end_of_text);
          end
          CH_RBRACE: begin
            emit = 1'b1;
            t = make_tok(KIND_RBRACE, pos_r, pos_t'(1), 1'b0, end_of_text);
          end
          CH_LBRACKET: begin
            emit = 1'b1;
            t = make_tok(KIND_LBRACKET, pos_r, pos_t'(1), 1'b0, end_of_text);
          end
          CH_RBRACKET: begin
            emit = 1'b1;
            t = make_tok(KIND_RBRACKET, pos_r, pos_t'(1), 1'b0, end_of_text);
          end
          CH_COLON: begin
            emit = 1'b1;
            t = make_tok(KIND_COLON, pos_r, pos_t'(1), 1'b0, end_of_text);
          end
          CH_COMMA: begin
            emit = 1'b1;
            t = make_tok(KIND_COMMA, pos_r, pos_t'(1), 1'b0, end_of_text);
          end
          CH_T: begin
            mode_nxt = MODE_TRUE;
            begin_nxt = pos_r;
          end
          CH_F: begin
            mode_nxt = MODE_FALSE;
            begin_nxt = pos_r;
          end
          CH_N: begin
            mode_nxt = MODE_NULL;
            begin_nxt = pos_r;
          end
          CH_QUOTE: begin
            mode_nxt = MODE_STRING;
            begin_nxt = pos_r;
            bs_nxt = 1'b0;
          end
          default: begin
            if ((text_byte == CH_MINUS) || (text_byte == CH_DOT) || is_digit(text_byte)) begin
              mode_nxt = MODE_NUMBER;
              begin_nxt = pos_r;
            end else begin
              emit = 1'b1;
              t = make_tok(KIND_LBRACE, pos_r, '0, 1'b1, end_of_text);
              halt_nxt = 1'b1;
            end
          end
        endcase
        if (emit) begin
          res[n[0]] = t;
          n = n + 2'd1;
        end
      end

      if (end_of_text) begin
        if (!halt_nxt) begin
          if (mode_nxt == MODE_STRING) begin
            res[n[0]] = make_tok(KIND_STRING, begin_nxt, nxt - begin_nxt, 1'b1, 1'b1);
            n = n + 2'd1;
          end else if (mode_nxt != MODE_IDLE) begin
            res[n[0]] = run_tok(mode_nxt, begin_nxt, nxt, 1'b1);
            n = n + 2'd1;
          end
        end
        mode_nxt = MODE_IDLE;
        begin_nxt = '0;
        pos_nxt = '0;
        bs_nxt = 1'b0;
        halt_nxt = 1'b0;
      end else begin
        pos_nxt = nxt;
      end
    end

    if (n == 2'd2) begin
      res[1].last = 1'b1;
    end else begin
      res[0].last = 1'b1;
    end

    result.tok0 = res[0];
    result.tok1 = res[1];
    result.cnt  = n;
  end

endmodule

>>> rtl/core/jtl_obuf.sv
module jtl_obuf
  import jtl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  scan_out_t result,
  output logic      can_load,
  output tok_t      out_tok,
  output logic      out_valid,
  input  logic      out_ready
);

  tok_t       slot0_r, slot0_nxt;
  tok_t       slot1_r, slot1_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;

  assign out_valid = (cnt_r != 2'd0);
  assign out_tok   = slot0_r;
  assign pop       = out_valid && out_ready;
  assign can_load  = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_ready);

  always_comb begin
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    cnt_nxt   = cnt_r;
    if (load) begin
      slot0_nxt = result.tok0;
      slot1_nxt = result.tok1;
      cnt_nxt   = result.cnt;
    end else if (pop) begin
      slot0_nxt = slot1_r;
      cnt_nxt   = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

endmodule

>>> rtl/core/json_token_lexer_unit.sv
// Path: input register, then combinational scanner into the output buffer.
// Throughput: one input word per cycle while the buffer can load; a word yielding
// two tokens holds the input until the second token drains from the buffer.
// Reset: synchronous active-low rst_n clears the scanner state, the input
// register and the output buffer; the next word starts a new text at offset 0.
module json_token_lexer_unit
  import jtl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] text_byte
  input  logic        in_tlast,   // end_of_text
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [3:0] token_kind, [19:4] token_offset,
                                  // [35:20] token_length, [39:36] zero
  output logic [1:0]  out_tuser,  // [0] lex_error, [1] text_done
  output logic        out_tlast   // run_last
);

  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;
  logic       can_load;
  logic       advance;
  scan_out_t  result;
  tok_t       out_tok;

  assign advance   = in_vld_r && can_load;
  assign in_tready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  jtl_scan u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .advance     (advance),
    .text_byte   (in_byte_r),
    .end_of_text (in_last_r),
    .result      (result)
  );

  jtl_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance),
    .result    (result),
    .can_load  (can_load),
    .out_tok   (out_tok),
    .out_valid (out_tvalid),
    .out_ready (out_tready)
  );

  assign out_tdata = {4'b0000, out_tok.length, out_tok.offset, out_tok.kind};
  assign out_tuser = {out_tok.done, out_tok.err};
  assign out_tlast = out_tok.last;

endmodule

>>> tb/sv/tb_json_token_lexer_unit.sv
module tb_json_token_lexer_unit;
  import jtl_pkg::*;

  localparam int STALL_LIMIT = 1000;
  localparam int RANDOM_BYTES = 600;

  class lexer_tracker;
    tok_t  pending_tokens[$];
    tok_t  step_toks[$];
    mode_t scan;
    pos_t  tok_start;
    pos_t  byte_pos;
    bit    escaped;
    bit    halted;
    int    fails;

    function new();
      restart();
      fails = 0;
    endfunction

    function void restart();
      scan = MODE_IDLE;
      tok_start = '0;
      byte_pos = '0;
      escaped = 1'b0;
      halted = 1'b0;
    endfunction

    function void report_mismatch(string what, int got, int want);
      $display("%0t: token mismatch on %s: got %0d, want %0d", $time, what, got, want);
      fails++;
    endfunction

    function void add_tok(logic [3:0] kind, pos_t off, pos_t len, bit err, bit done);
      tok_t t;
      t.kind = kind;
      t.offset = off;
      t.length = len;
      t.err = err;
      t.last = 1'b0;
      t.done = done;
      step_toks.push_back(t);
    endfunction

    function bit run_goes_on(logic [7:0] c);
      case (scan)
        MODE_NUMBER: return (c inside {CH_MINUS, CH_PLUS, CH_DOT, CH_UPPER_E, CH_E}) ||
                            (c >= CH_ZERO && c <= CH_NINE);
        MODE_TRUE:   return c inside {CH_R, CH_U, CH_E};
        MODE_FALSE:  return c inside {CH_A, CH_L, CH_S, CH_E};
        MODE_NULL:   return c inside {CH_U, CH_L};
        default:     return 1'b0;
      endcase
    endfunction

    function void flush_run(pos_t stop, bit done);
      case (scan)
        MODE_TRUE:  add_tok(KIND_TRUE, tok_start, 4, 1'b0, done);
        MODE_FALSE: add_tok(KIND_FALSE, tok_start, 5, 1'b0, done);
        MODE_NULL:  add_tok(KIND_NULL, tok_start, 4, 1'b0, done);
        default:    add_tok(KIND_NUMBER, tok_start,
                            (stop > tok_start) ? stop - tok_start : '0, 1'b0, done);
      endcase
      scan = MODE_IDLE;
    endfunction

    function void note_byte(logic [7:0] c, bit eot);
      pos_t p;
      pos_t nxt;
      bit   used;
      p = byte_pos;
      nxt = (p == '1) ? p : p + 1'b1;
      used = 1'b0;
      step_toks.delete();
      if (halted) begin
        if (eot) restart();
        return;
      end
      if (scan == MODE_STRING) begin
        used = 1'b1;
        if (escaped) begin
          escaped = 1'b0;
        end else if (c == CH_BSLASH) begin
          escaped = 1'b1;
        end else if (c == CH_QUOTE) begin
          add_tok(KIND_STRING, tok_start, nxt - tok_start, 1'b0, eot);
          scan = MODE_IDLE;
        end
      end else if (scan != MODE_IDLE) begin
        if (run_goes_on(c)) used = 1'b1;
        else flush_run(p, eot);
      end
      if (!used) begin
        case (c)
          CH_SPACE, CH_TAB, CH_FF, CH_CR, CH_LF: ;
          CH_LBRACE:   add_tok(KIND_LBRACE, p, 1, 1'b0, eot);
          CH_RBRACE:   add_tok(KIND_RBRACE, p, 1, 1'b0, eot);
          CH_LBRACKET: add_tok(KIND_LBRACKET, p, 1, 1'b0, eot);
          CH_RBRACKET: add_tok(KIND_RBRACKET, p, 1, 1'b0, eot);
          CH_COLON:    add_tok(KIND_COLON, p, 1, 1'b0, eot);
          CH_COMMA:    add_tok(KIND_COMMA, p, 1, 1'b0, eot);
          CH_T: begin
            scan = MODE_TRUE;
            tok_start = p;
          end
          CH_F: begin
            scan = MODE_FALSE;
            tok_start = p;
          end
          CH_N: begin
            scan = MODE_NULL;
            tok_start = p;
          end
          CH_QUOTE: begin
            scan = MODE_STRING;
            tok_start = p;
            escaped = 1'b0;
          end
          default: begin
            if (c == CH_MINUS || c == CH_DOT || (c >= CH_ZERO && c <= CH_NINE)) begin
              scan = MODE_NUMBER;
              tok_start = p;
            end else begin
              // error records carry a zero kind
              add_tok(KIND_LBRACE, p, 0, 1'b1, eot);
              halted = 1'b1;
            end
          end
        endcase
      end
      if (eot) begin
        if (!halted) begin
          if (scan == MODE_STRING) add_tok(KIND_STRING, tok_start, nxt - tok_start, 1'b1, 1'b1);
          else if (scan != MODE_IDLE) flush_run(nxt, 1'b1);
        end
        restart();
      end else begin
        byte_pos = nxt;
      end
      if (step_toks.size() > 0) step_toks[step_toks.size()-1].last = 1'b1;
      foreach (step_toks[i]) pending_tokens.push_back(step_toks[i]);
    endfunction

    function void check_token(logic [39:0] data, logic [1:0] user, logic last);
      tok_t want;
      if (pending_tokens.size() == 0) begin
        report_mismatch("unexpected token kind", data[3:0], 0);
        return;
      end
      want = pending_tokens.pop_front();
      if (data[3:0] !== want.kind) report_mismatch("kind", data[3:0], want.kind);
      if (data[19:4] !== want.offset) report_mismatch("offset", data[19:4], want.offset);
      if (data[35:20] !== want.length) report_mismatch("length", data[35:20], want.length);
      if (data[39:36] !== 4'd0) report_mismatch("padding", data[39:36], 0);
      if (user[0] !== want.err) report_mismatch("lex_error", user[0], want.err);
      if (user[1] !== want.done) report_mismatch("text_done", user[1], want.done);
      if (last !== want.last) report_mismatch("run_last", last, want.last);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  lexer_tracker tracker = new();
  logic [7:0]   text_buf[$];
  bit           idle_on = 1'b1;
  int           quiet_cycles = 0;
  int           random_sent = 0;
  bit           paused = 1'b0;

  json_token_lexer_unit DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .out_tlast(out_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles = 0;
    end else begin
      if (in_tvalid && in_tready) tracker.note_byte(in_tdata, in_tlast);
      if (out_tvalid && out_tready) tracker.check_token(out_tdata, out_tuser, out_tlast);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
  end

  task automatic send_byte(logic [7:0] b, bit eot);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= eot;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_text();
    foreach (text_buf[i]) send_byte(text_buf[i], i == text_buf.size() - 1);
    text_buf.delete();
  endtask

  task automatic queue_string(string s);
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (tracker.pending_tokens.size() != 0);
  endtask

  function automatic logic [7:0] pick_char(string set);
    return set[$urandom_range(0, set.len() - 1)];
  endfunction

  task automatic add_space();
    logic [7:0] ws_chars[5];
    ws_chars = '{CH_SPACE, CH_TAB, CH_FF, CH_CR, CH_LF};
    repeat ($urandom_range(1, 3)) text_buf.push_back(ws_chars[$urandom_range(0, 4)]);
  endtask

  task automatic add_token();
    string word_tail;
    string word_set;
    logic [7:0] lead;
    case ($urandom_range(0, 8))
      0, 1, 2: text_buf.push_back(pick_char("{}[]:,"));
      3, 4: begin
        text_buf.push_back(pick_char("-.0123456789"));
        repeat ($urandom_range(0, 5)) text_buf.push_back(pick_char("-+.Ee0123456789"));
      end
      5: begin
        case ($urandom_range(0, 2))
          0: begin lead = CH_T; word_tail = "rue"; word_set = "rue"; end
          1: begin lead = CH_F; word_tail = "alse"; word_set = "alse"; end
          default: begin lead = CH_N; word_tail = "ull"; word_set = "ul"; end
        endcase
        text_buf.push_back(lead);
        if ($urandom_range(0, 1)) queue_string(word_tail);
        else repeat ($urandom_range(0, 4)) text_buf.push_back(pick_char(word_set));
      end
      6, 7: begin
        text_buf.push_back(CH_QUOTE);
        repeat ($urandom_range(0, 8)) begin
          if ($urandom_range(0, 4) == 0) text_buf.push_back(CH_BSLASH);
          text_buf.push_back(8'($urandom_range(32, 126)));
        end
        text_buf.push_back(CH_QUOTE);
      end
      default: add_space();
    endcase
    if ($urandom_range(0, 1)) add_space();
  endtask

  task automatic build_text();
    int spot;
    repeat ($urandom_range(1, 10)) add_token();
    if ($urandom_range(0, 9) == 0) begin
      spot = $urandom_range(0, text_buf.size());
      text_buf.insert(spot, 8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 11) == 0) begin
      text_buf.push_back(CH_QUOTE);
      repeat ($urandom_range(0, 4)) text_buf.push_back(pick_char("ab\\ \""));
    end
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && idle_on && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      out_tready <= rst_n;
    end
  end

  initial begin
    wait (rst_n);
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    queue_string("{\"\\\"\\\\\":-.5e+E}");
    send_text();
    queue_string("[t,f n]");
    send_text();
    queue_string("\"ab");
    send_text();
    text_buf = '{8'h00, 8'hFF, CH_LBRACE};
    send_text();
    queue_string("7");
    send_text();

    while (random_sent < RANDOM_BYTES) begin
      idle_on = (random_sent < RANDOM_BYTES * 4 / 5) ? ($urandom_range(0, 3) != 0) : 1'b0;
      build_text();
      random_sent += text_buf.size();
      send_text();
      if (!paused && random_sent > RANDOM_BYTES / 2) begin
        wait_drained();
        paused = 1'b1;
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (tracker.pending_tokens.size() != 0)
      tracker.report_mismatch("tokens never produced", tracker.pending_tokens.size(), 0);
    if (tracker.fails == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

>>> json_token_lexer_unit.f
rtl/core/jtl_pkg.sv
rtl/core/jtl_scan.sv
rtl/core/jtl_obuf.sv
rtl/core/json_token_lexer_unit.sv
tb/sv/tb_json_token_lexer_unit.sv
